// ----- sv/fir_clamped_edge_convolution_assert.svh -----
// Assertion macros for the clamped-edge FIR filter.
`ifndef FIR_CLAMPED_EDGE_CONVOLUTION_ASSERT_SVH
`define FIR_CLAMPED_EDGE_CONVOLUTION_ASSERT_SVH
`ifndef SYNTH
`define FCE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fce same-cycle check failed");
`define FCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fce next-cycle check failed");
`else
`define FCE_ASSERT_SAME(lbl, ante, cons)
`define FCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/fce_pkg.sv -----
// Shared types and constants of the clamped-edge FIR filter.
package fce_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 16;
  localparam int COEF_FRAC_BITS = 15;
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS + 1;
  localparam int TAP_IDX_BITS   = 7;

  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic                        mode;
    logic [5:0]                  coef_index;
    logic signed [COEF_BITS-1:0] coef_value;
    logic [SAMPLE_BITS-1:0]      sample;
    logic                        row_end;
  } fce_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] filtered;
    logic                   clipped;
    logic                   final_res;
  } fce_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT,
    ST_FLUSH
  } fce_state_t;

  typedef struct packed {
    logic                    load_coef;
    logic                    push;
    logic                    row_start;
    logic                    flush_push;
    logic                    tap_valid;
    logic                    tap_last;
    logic [TAP_IDX_BITS-1:0] tap_idx;
    logic [TAP_IDX_BITS-1:0] win_idx;
    logic                    out_load;
    logic                    out_final;
  } fce_cmd_t;

  typedef struct packed {
    logic acc_done;
  } fce_stat_t;

endpackage

// ----- sv/fce_ctrl.sv -----
// Controller: request handshake, row bookkeeping and tap sequencing.
module fce_ctrl #(
  parameter int MAX_TAPS = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  input  fce_pkg::fce_in_t   in_data,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  fce_pkg::fce_stat_t stat,
  output fce_pkg::fce_cmd_t  cmd
);

  localparam int TW  = $clog2(MAX_TAPS + 1);
  localparam int LIM = (MAX_TAPS - 1) / 2;

  fce_pkg::fce_state_t state_r, state_nxt;
  logic [4:0]    half_width_r;
  logic [4:0]    n_eff;
  logic [4:0]    n_r, n_nxt;
  logic [5:0]    row_cnt_r, row_cnt_nxt;
  logic [5:0]    pos_r, pos_nxt;
  logic [4:0]    j_r, j_nxt;
  logic [TW-1:0] k_r, k_nxt;
  logic          last_r, last_nxt;
  logic [TW-1:0] two_n;
  logic [4:0]    j_inc;
  logic [6:0]    reach;

  always_comb begin
    if (int'(half_width_r) > LIM) begin
      n_eff = 5'(LIM);
    end else begin
      n_eff = half_width_r;
    end
  end

  assign two_n = TW'({1'b0, n_r, 1'b0});
  assign j_inc = j_r + 5'd1;
  assign reach = {1'b0, pos_r} + {2'b00, j_inc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= 5'd1;
    end else if (cfg_we) begin
      half_width_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fce_pkg::ST_IDLE;
      row_cnt_r <= '0;
      n_r       <= '0;
      pos_r     <= '0;
      j_r       <= '0;
      k_r       <= '0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_cnt_r <= row_cnt_nxt;
      n_r       <= n_nxt;
      pos_r     <= pos_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
      last_r    <= last_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    row_cnt_nxt = row_cnt_r;
    n_nxt       = n_r;
    pos_nxt     = pos_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    last_nxt    = last_r;
    cmd         = '0;
    cmd.tap_idx = 7'(k_r);
    cmd.win_idx = 7'(two_n - k_r);
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    unique case (state_r)
      fce_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_data.mode == fce_pkg::MODE_COEF) begin
            cmd.load_coef = 1'b1;
          end else begin
            cmd.push      = 1'b1;
            cmd.row_start = (row_cnt_r == '0);
            n_nxt         = n_eff;
            pos_nxt       = row_cnt_r;
            j_nxt         = '0;
            k_nxt         = '0;
            last_nxt      = in_data.row_end;
            if (in_data.row_end) begin
              row_cnt_nxt = '0;
            end else if (row_cnt_r != 6'd63) begin
              row_cnt_nxt = row_cnt_r + 6'd1;
            end
            if (row_cnt_r >= {1'b0, n_eff}) begin
              state_nxt = fce_pkg::ST_ISSUE;
            end else if (in_data.row_end) begin
              state_nxt = fce_pkg::ST_FLUSH;
            end
          end
        end
      end
      fce_pkg::ST_ISSUE: begin
        cmd.tap_valid = 1'b1;
        cmd.tap_last  = (k_r == two_n);
        k_nxt         = k_r + TW'(1);
        if (k_r == two_n) begin
          state_nxt = fce_pkg::ST_DRAIN;
        end
      end
      fce_pkg::ST_DRAIN: begin
        if (stat.acc_done) begin
          cmd.out_load  = 1'b1;
          cmd.out_final = last_r && (j_r == n_r);
          state_nxt     = fce_pkg::ST_OUT;
        end
      end
      fce_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (last_r && (j_r != n_r)) begin
            state_nxt = fce_pkg::ST_FLUSH;
          end else begin
            state_nxt = fce_pkg::ST_IDLE;
          end
        end
      end
      fce_pkg::ST_FLUSH: begin
        // replicate the last sample once more past the row end
        cmd.flush_push = 1'b1;
        j_nxt          = j_inc;
        k_nxt          = '0;
        if (reach >= {2'b00, n_r}) begin
          state_nxt = fce_pkg::ST_ISSUE;
        end
      end
      default: begin
        state_nxt = fce_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/fce_dpath.sv -----
// Datapath: coefficient store, sample ring, multiply-accumulate and rounding.
module fce_dpath #(
  parameter int MAX_TAPS = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fce_pkg::fce_in_t   in_data,
  input  fce_pkg::fce_cmd_t  cmd,
  output fce_pkg::fce_stat_t stat,
  output fce_pkg::fce_out_t  out_data
);

  localparam int TW    = $clog2(MAX_TAPS + 1);
  localparam int SB    = fce_pkg::SAMPLE_BITS;
  localparam int CB    = fce_pkg::COEF_BITS;
  localparam int FB    = fce_pkg::COEF_FRAC_BITS;
  localparam int PB    = fce_pkg::PROD_BITS;
  localparam int ACC_W = PB + TW;

  logic signed [CB-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]  coef_vld_r;
  logic [SB-1:0]        win_mem [2**TW];

  logic [TW-1:0]        wr_ptr_r;
  logic [TW-1:0]        fill_r;
  logic [SB-1:0]        first_r;
  logic [SB-1:0]        samp_r;

  logic                 coef_ok;
  logic [TW-1:0]        coef_waddr;
  logic [TW-1:0]        tap_addr;
  logic [TW-1:0]        win_off;
  logic [TW-1:0]        win_raddr;
  logic                 win_we;
  logic [SB-1:0]        win_wdata;

  logic signed [CB-1:0] coef_rd_r;
  logic                 coef_hit_r;
  logic [SB-1:0]        samp_rd_r;
  logic                 use_first_r;
  logic                 v1_r, last1_r;

  logic signed [CB-1:0] coef_op;
  logic [SB-1:0]        samp_op;
  logic signed [PB-1:0] prod_r;
  logic                 v2_r, last2_r;

  logic signed [ACC_W-1:0] acc_r;
  logic                    acc_done_r;
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [ACC_W-1:0] rnd_shr;
  logic [SB-1:0]           res_val;
  logic                    res_clip;

  assign coef_ok    = int'(in_data.coef_index) < MAX_TAPS;
  assign coef_waddr = TW'(in_data.coef_index);
  assign tap_addr   = TW'(cmd.tap_idx);
  assign win_off    = TW'(cmd.win_idx);
  assign win_raddr  = wr_ptr_r - TW'(1) - win_off;
  assign win_we     = cmd.push || cmd.flush_push;
  assign win_wdata  = cmd.push ? in_data.sample : samp_r;

  always_ff @(posedge clk) begin
    if (cmd.load_coef && coef_ok) begin
      coef_mem[coef_waddr] <= in_data.coef_value;
    end
    if (cmd.tap_valid) begin
      coef_rd_r <= coef_mem[tap_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[wr_ptr_r] <= win_wdata;
    end
    if (cmd.tap_valid) begin
      samp_rd_r <= win_mem[win_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (cmd.load_coef && coef_ok) begin
      coef_vld_r[coef_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (win_we) begin
      wr_ptr_r <= wr_ptr_r + TW'(1);
      if (cmd.row_start) begin
        fill_r <= TW'(1);
      end else if (fill_r != TW'(MAX_TAPS)) begin
        fill_r <= fill_r + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      samp_r <= in_data.sample;
      if (cmd.row_start) begin
        first_r <= in_data.sample;
      end
    end
    if (cmd.tap_valid) begin
      coef_hit_r  <= coef_vld_r[tap_addr];
      // positions older than the row start repeat the first sample
      use_first_r <= (win_off >= fill_r);
    end
  end

  assign coef_op = coef_hit_r ? coef_rd_r : '0;
  assign samp_op = use_first_r ? first_r : samp_rd_r;

  always_ff @(posedge clk) begin
    prod_r <= coef_op * $signed({1'b0, samp_op});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      last1_r    <= 1'b0;
      v2_r       <= 1'b0;
      last2_r    <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      v1_r       <= cmd.tap_valid;
      last1_r    <= cmd.tap_valid && cmd.tap_last;
      v2_r       <= v1_r;
      last2_r    <= last1_r;
      acc_done_r <= v2_r && last2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign rnd_sum = acc_r + (ACC_W'(1) <<< (FB - 1));
  assign rnd_shr = rnd_sum >>> FB;

  always_comb begin
    if (rnd_sum[ACC_W-1]) begin
      res_val  = '0;
      res_clip = 1'b1;
    end else if (rnd_shr[ACC_W-1:SB] != '0) begin
      res_val  = '1;
      res_clip = 1'b1;
    end else begin
      res_val  = rnd_shr[SB-1:0];
      res_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.filtered  <= res_val;
      out_data.clipped   <= res_clip;
      out_data.final_res <= cmd.out_final;
    end
  end

  assign stat.acc_done = acc_done_r;

endmodule

// ----- sv/fir_clamped_edge_convolution.sv -----
// Top level of the clamped-edge FIR filter.
// Streaming 1-D FIR with replicated row borders. A mode-0 request writes one
// Q1.15 coefficient; a mode-1 request pushes one sample. Each output runs the
// 2N+1 taps through a single multiply-accumulate unit, one tap per cycle from
// the coefficient and sample memories. A sample that completes an output
// holds the input until its taps are accumulated and its result is taken.
// The sample marked row_end replays itself N more times, each replay writing
// the sample again and running an output pass when it completes a position.
// One request is in flight at a time; in_stall is high until its results are
// delivered. The user must write half_width through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
module fir_clamped_edge_convolution #(
  parameter int MAX_TAPS = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  logic              in_valid,
  input  fce_pkg::fce_in_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  output fce_pkg::fce_out_t out_data,
  input  logic              out_stall
);

  fce_pkg::fce_cmd_t  cmd;
  fce_pkg::fce_stat_t stat;

  fce_ctrl #(
    .MAX_TAPS(MAX_TAPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fce_dpath #(
    .MAX_TAPS(MAX_TAPS)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );

`include "fir_clamped_edge_convolution_assert.svh"

  `FCE_ASSERT_SAME(a_no_accept_with_result, out_valid, in_stall)
  `FCE_ASSERT_NEXT(a_final_ends_row, out_valid && !out_stall && out_data.final_res, !out_valid)
  `FCE_ASSERT_NEXT(a_coef_silent, in_valid && !in_stall && (in_data.mode == fce_pkg::MODE_COEF), !out_valid)

endmodule
